// ===== design/integer_matrix_determinant_assert.svh =====
// Assertion macros for the determinant block controller module.
// Depends on nothing; included by modules that carry assertions.
`ifndef INTEGER_MATRIX_DETERMINANT_ASSERT_SVH
`define INTEGER_MATRIX_DETERMINANT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define IMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define IMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/imd_pkg.sv =====
// Package for the integer matrix determinant block.
// Holds sizes, state encoding and the controller to datapath struct.
package imd_pkg;
  localparam int unsigned MaxOrder   = 6;
  localparam int unsigned StoreDepth = MaxOrder * MaxOrder;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned ElemW      = 8;
  localparam int unsigned DetW       = 52;
  localparam int unsigned OrderW     = 3;
  localparam int unsigned NumSub     = 64;
  localparam int unsigned SubW       = 6;
  localparam logic [OrderW-1:0] OrderReset = 3'd3;
  localparam int unsigned AddrW      = 1;
  localparam logic [AddrW-1:0] RegOrder = 1'b0;

  typedef enum logic [2:0] {
    StLoad,
    StInit,
    StRead,
    StMul,
    StAcc,
    StOut
  } state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic            init;
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
    logic [SubW-1:0] sub_set;
    logic [SubW-1:0] acc_set;
    logic            neg;
    logic            mul;
    logic            acc;
    logic            base;
  } cmd_t;
endpackage

// ===== design/imd_stream_if.sv =====
// Valid/ready stream interface with a parameterless payload.
// Depends on imd_pkg for the payload width.
interface imd_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [imd_pkg::ElemW-1:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface imd_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [imd_pkg::DetW-1:0] determinant;
  modport source (output valid, output determinant, input ready);
  modport sink (input valid, input determinant, output ready);
endinterface

// ===== design/integer_matrix_determinant.sv =====
// Integer matrix determinant, orders 1 to 6, one element beat per cycle while loading.
// After the last element a subset-minor sweep runs on one multiplier: it scans subsets,
// skips columns outside each subset, and reads, multiplies and accumulates each product.
// The block takes one matrix at a time. Reset clears control and sets order to 3.
module integer_matrix_determinant (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  imd_in_if.sink                              in_if,
  imd_out_if.source                           out_if,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [imd_pkg::AddrW+1:0]           paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  logic [imd_pkg::OrderW-1:0] order_q;
  logic wr;
  imd_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[imd_pkg::AddrW+1:2] == imd_pkg::RegOrder);
  assign prdata = 32'(order_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) order_q <= imd_pkg::OrderReset;
    else if (wr) order_q <= pwdata[imd_pkg::OrderW-1:0];
  end

  imd_ctrl u_ctrl (
    .clk_i, .rst_ni, .order_i(order_q), .clr_i(wr),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .cmd_o(cmd)
  );

  imd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .elem_i(in_if.element_value), .det_o(out_if.determinant)
  );
endmodule

// ===== design/imd_datapath.sv =====
// Datapath: element store, subset determinant table and one multiplier.
// Depends on imd_pkg; driven by imd_ctrl through cmd_t.
module imd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  imd_pkg::cmd_t                  cmd_i,
  input  logic signed [imd_pkg::ElemW-1:0] elem_i,
  output logic signed [imd_pkg::DetW-1:0] det_o
);
  // minor table: determinant of bottom rows over each column subset
  logic signed [imd_pkg::ElemW-1:0] store_q [imd_pkg::StoreDepth];
  logic signed [imd_pkg::DetW-1:0]  sub_q [imd_pkg::NumSub];
  logic signed [imd_pkg::ElemW-1:0] elem_q;
  logic signed [imd_pkg::DetW-1:0]  minor_q, prod_q, acc_q;
  logic signed [imd_pkg::DetW-1:0]  elem_ext, acc_sum, acc_d;

  assign elem_ext = {{(imd_pkg::DetW - imd_pkg::ElemW){elem_q[imd_pkg::ElemW-1]}}, elem_q};
  assign acc_sum  = cmd_i.neg ? acc_q - prod_q : acc_q + prod_q;
  assign acc_d    = cmd_i.base ? elem_ext : acc_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) store_q[cmd_i.wr_idx] <= elem_i;
    if (cmd_i.rd_en) begin
      elem_q  <= store_q[cmd_i.rd_idx];
      minor_q <= sub_q[cmd_i.sub_set];
    end
    if (cmd_i.acc) sub_q[cmd_i.acc_set] <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (cmd_i.mul) prod_q <= elem_ext * minor_q;
      if (cmd_i.init) acc_q <= '0;
      else if (cmd_i.acc) acc_q <= acc_d;
    end
  end

  assign det_o = acc_q;
endmodule

// ===== design/imd_ctrl.sv =====
// Controller: loads elements, then walks column subsets bottom row up.
// Depends on imd_pkg and the assertion macro header.
`include "integer_matrix_determinant_assert.svh"
module imd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [imd_pkg::OrderW-1:0]        order_i,
  input  logic                              clr_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output imd_pkg::cmd_t                     cmd_o
);
  imd_pkg::state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] n;
  logic [5:0] total;
  logic [2:0] row_q, row_d;       // row being processed
  logic [5:0] set_q, set_d;       // column subset, popcount = n - row
  logic [2:0] col_q, col_d;       // column inside subset
  logic       neg_q, neg_d;
  logic [5:0] full;
  logic       in_set, last_col, last_set, sub_base;
  logic [5:0] set_rem;
  logic [2:0] pc;

  always_comb begin
    n = (order_i == 3'd0) ? 3'd1 : (order_i > 3'd6) ? 3'd6 : order_i;
    total = 6'(n) * 6'(n);
    full = 6'((7'd1 << n) - 7'd1);
    pc = 3'($countones(set_q));
    in_set = set_q[col_q];
    last_col = (col_q == n - 3'd1) || ((set_q >> (col_q + 3'd1)) == 6'd0);
    last_set = (set_q == full);
    sub_base = (row_q == n - 3'd1);
    set_rem = set_q & ~(6'd1 << col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imd_pkg::StLoad; cnt_q <= '0; row_q <= '0;
      set_q <= '0; col_q <= '0; neg_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; row_q <= row_d;
      set_q <= set_d; col_q <= col_d; neg_q <= neg_d;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; row_d = row_q; set_d = set_q;
    col_d = col_q; neg_d = neg_q;
    unique case (state_q)
      imd_pkg::StLoad: begin
        if (clr_i) cnt_d = '0;
        else if (in_valid_i) begin
          if (cnt_q + 6'd1 >= total) begin
            cnt_d = '0; state_d = imd_pkg::StInit;
            row_d = n - 3'd1; set_d = 6'd1; col_d = '0; neg_d = 1'b0;
          end else cnt_d = cnt_q + 6'd1;
        end
      end
      imd_pkg::StInit: begin
        // scan one subset per cycle; move up a row once the row's subsets are done
        if (pc == n - row_q) state_d = imd_pkg::StRead;
        else if (set_q == full) begin
          row_d = row_q - 3'd1;
          set_d = 6'((7'd1 << (n - row_q + 3'd1)) - 7'd1);
        end else set_d = set_q + 6'd1;
      end
      imd_pkg::StRead: begin
        if (!in_set) col_d = col_q + 3'd1;
        else state_d = imd_pkg::StMul;
      end
      imd_pkg::StMul: state_d = imd_pkg::StAcc;
      imd_pkg::StAcc: begin
        neg_d = ~neg_q; col_d = col_q + 3'd1; state_d = imd_pkg::StRead;
        if (last_col || sub_base) begin
          col_d = '0; neg_d = 1'b0;
          if (last_set) state_d = imd_pkg::StOut;
          else begin
            state_d = imd_pkg::StInit;
            set_d = set_q + 6'd1;
          end
        end
      end
      imd_pkg::StOut: if (out_ready_i) state_d = imd_pkg::StLoad;
      default: state_d = imd_pkg::StLoad;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == imd_pkg::StLoad);
    out_valid_o = (state_q == imd_pkg::StOut);
    cmd_o.wr_en = in_ready_o && in_valid_i;
    cmd_o.wr_idx = cnt_q;
    cmd_o.init = (state_q == imd_pkg::StInit);
    cmd_o.rd_en = (state_q == imd_pkg::StRead);
    cmd_o.rd_idx = 6'(row_q) * 6'(n) + 6'(col_q);
    cmd_o.sub_set = set_rem;
    cmd_o.acc_set = set_q;
    cmd_o.neg = neg_q;
    cmd_o.mul = (state_q == imd_pkg::StMul);
    cmd_o.acc = (state_q == imd_pkg::StAcc);
    cmd_o.base = sub_base;
  end

  `IMD_ASSERT_IMPL(a_no_both, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o))
  `IMD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `IMD_ASSERT_IMPL(a_cnt_rng, clk_i, rst_ni, in_ready_o, cnt_q < 6'd36)
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for integer_matrix_determinant: streams matrix elements,
// predicts each determinant by cofactor expansion and checks every result beat.
// Depends on imd_pkg and the imd_in_if / imd_out_if interfaces of the design.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [imd_pkg::AddrW+1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  imd_in_if in_if ();
  imd_out_if out_if ();

  integer_matrix_determinant uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: order register, element store and load count.
  logic [imd_pkg::OrderW-1:0] order_reg = imd_pkg::OrderReset;
  longint elem_store [imd_pkg::StoreDepth];
  int unsigned load_cnt = 0;

  logic signed [imd_pkg::ElemW-1:0] elem_pend [$];
  logic [imd_pkg::DetW-1:0] det_expected [$];
  bit idle_on = 1'b1;
  int err_cnt = 0;
  logic [imd_pkg::OrderW-1:0] orders [9] = '{3'd6, 3'd1, 3'd2, 3'd0, 3'd7, 3'd4, 3'd5,
                                             3'd3, 3'd6};

  function automatic int unsigned active_order();
    int unsigned n;
    n = order_reg;
    if (n < 1) n = 1;
    if (n > imd_pkg::MaxOrder) n = imd_pkg::MaxOrder;
    return n;
  endfunction

  // Determinant of rows row..n-1 restricted to the columns set in cols.
  function automatic longint cofactor_det(int unsigned row, logic [5:0] cols, int unsigned n);
    longint sum;
    bit flip;
    sum = 0;
    flip = 1'b0;
    for (int unsigned c = 0; c < n; c++) begin
      if (cols[c]) begin
        if (row + 1 >= n) return elem_store[row * n + c];
        if (flip) sum -= elem_store[row * n + c] * cofactor_det(row + 1, cols & ~(6'd1 << c), n);
        else sum += elem_store[row * n + c] * cofactor_det(row + 1, cols & ~(6'd1 << c), n);
        flip = !flip;
      end
    end
    return sum;
  endfunction

  function automatic void load_element(logic signed [imd_pkg::ElemW-1:0] v);
    int unsigned n;
    longint d;
    n = active_order();
    if (load_cnt >= n * n) load_cnt = 0;
    elem_store[load_cnt] = longint'(v);
    load_cnt++;
    if (load_cnt >= n * n) begin
      load_cnt = 0;
      d = cofactor_det(0, 6'((1 << n) - 1), n);
      det_expected.push_back(d[imd_pkg::DetW-1:0]);
    end
  endfunction

  // Element driver: advance on accept, gap at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.element_value <= '0;
    end else begin
      if (in_if.valid && in_if.ready) load_element(in_if.element_value);
      if (!in_if.valid || in_if.ready) begin
        if (elem_pend.size() > 0 && !(idle_on && $urandom_range(99) < 6)) begin
          in_if.valid <= 1'b1;
          in_if.element_value <= elem_pend.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [imd_pkg::DetW-1:0] want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (det_expected.size() == 0) begin
          $error("unexpected determinant beat %0d", $signed(out_if.determinant));
          err_cnt++;
        end else begin
          want = det_expected.pop_front();
          if (out_if.determinant !== want) begin
            $error("determinant: expected %0d, actual %0d", $signed(want),
                   $signed(out_if.determinant));
            err_cnt++;
          end
        end
      end
      out_if.ready <= !(idle_on && $urandom_range(99) < 6);
    end
  end

  task automatic wait_drained();
    while (elem_pend.size() > 0 || in_if.valid || det_expected.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_order(logic [imd_pkg::OrderW-1:0] val);
    wait_drained();
    repeat (20) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {imd_pkg::RegOrder, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    order_reg = val;
    load_cnt = 0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [imd_pkg::ElemW-1:0] pick_element();
    int unsigned r;
    r = $urandom_range(255);
    case ($urandom_range(9))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return '0;
      default: return r[imd_pkg::ElemW-1:0];
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned cnt;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset order is 3: all-minimum (singular) and a mixed extreme matrix.
    repeat (9) elem_pend.push_back(-8'sd128);
    elem_pend.push_back(8'sd127); elem_pend.push_back(-8'sd128); elem_pend.push_back(8'sd0);
    elem_pend.push_back(8'sd0); elem_pend.push_back(8'sd127); elem_pend.push_back(-8'sd128);
    elem_pend.push_back(-8'sd128); elem_pend.push_back(8'sd0); elem_pend.push_back(8'sd127);
    // Partly loaded matrix, dropped by the next register write.
    repeat (4) elem_pend.push_back(8'sd5);
    write_order(3'd1);
    elem_pend.push_back(-8'sd128);
    elem_pend.push_back(8'sd127);

    foreach (orders[p]) begin
      write_order(orders[p]);
      idle_on = (p != 5);
      n = (orders[p] < 1) ? 1 : (orders[p] > imd_pkg::MaxOrder ? imd_pkg::MaxOrder : orders[p]);
      cnt = 0;
      while (cnt < 125) begin
        for (int unsigned k = 0; k < n * n; k++) elem_pend.push_back(pick_element());
        cnt += n * n;
        // Hold the sender once until every determinant is back.
        if (p == 2 && cnt >= 75 && cnt < 75 + n * n) wait_drained();
      end
      if (p == 7) repeat (2) elem_pend.push_back(pick_element());
    end

    wait_drained();
    repeat (1000) @(posedge clk_i);
    if (det_expected.size() > 0) begin
      $error("%0d determinants never arrived", det_expected.size());
      err_cnt++;
    end
    if (err_cnt == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/imd_pkg.sv
design/imd_stream_if.sv
design/imd_datapath.sv
design/imd_ctrl.sv
design/integer_matrix_determinant.sv
dv/tb.sv
